@@ src/bfha_pkg.sv @@
// Package for the best-fit heap allocator: sizes, status codes and item types.
// No dependencies; used by the allocator unit and its checker.
package bfha_pkg;

	localparam int HEAP_BYTES  = 65536;
	localparam int TABLE_SLOTS = 1024;
	localparam int IDX_W       = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = IDX_W + 1;

	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TABLE_SLOTS);
	localparam logic [17:0]      HEAP_C  = 18'(HEAP_BYTES);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_HEAP     = 3'd1;
	localparam logic [2:0] ST_TABLE    = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_ZERO     = 3'd4;

	typedef struct packed {
		logic        func;
		logic [16:0] req_size;
		logic [15:0] free_offset;
	} bfha_req_t;

	typedef struct packed {
		logic [15:0] offset;
		logic [2:0]  status;
	} bfha_rsp_t;

	// one entry of the sorted free list
	typedef struct packed {
		logic [15:0] start;
		logic [16:0] len;
	} fl_ent_t;

	// one entry of the slot table
	typedef struct packed {
		logic        valid;
		logic [15:0] start;
		logic [16:0] len;
	} slot_ent_t;

endpackage

@@ src/best_fit_heap_allocator_unit.sv @@
// Best-fit heap allocator: sequencer around three single-port-style memories.
// Depends on bfha_pkg (sizes, status codes, item and entry types).
//
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        req  (bfha_pkg::bfha_req_t)
// response  out        done, one cycle      rsp  (bfha_pkg::bfha_rsp_t)
//
// Items: one at a time. An allocate scans the free list (F entries) and
// closes the gap behind the taken chunk, re-inserts the split remainder, then
// takes a slot; a free scans the S opened slots, then makes the sorted
// insertion. Every step is one memory read followed by its compare or write.
// Reset: clears state, done, counters and bump pointer only; slot entries at or above the
// open-slot count are never read, so memories need no clearing pass.
// Stalls: none on the output; busy holds start off while an item is at work.
module best_fit_heap_allocator_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  bfha_pkg::bfha_req_t   req,
	output logic                  done,
	output bfha_pkg::bfha_rsp_t   rsp
);

	localparam int IW = bfha_pkg::IDX_W;
	localparam int CW = bfha_pkg::CNT_W;

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_FSCAN_RD = 4'd1;
	localparam logic [3:0] S_FSCAN_CK = 4'd2;
	localparam logic [3:0] S_DECIDE   = 4'd3;
	localparam logic [3:0] S_RM_RD    = 4'd4;
	localparam logic [3:0] S_RM_WR    = 4'd5;
	localparam logic [3:0] S_INS_RD   = 4'd6;
	localparam logic [3:0] S_INS_CK   = 4'd7;
	localparam logic [3:0] S_STK      = 4'd8;
	localparam logic [3:0] S_STK_CK   = 4'd9;
	localparam logic [3:0] S_SLOT_WR  = 4'd10;
	localparam logic [3:0] S_SSCAN_RD = 4'd11;
	localparam logic [3:0] S_SSCAN_CK = 4'd12;
	localparam logic [3:0] S_FREE_DO  = 4'd13;

	// memories: sorted free list, slot table, released-slot stack
	bfha_pkg::fl_ent_t   fl_mem   [bfha_pkg::TABLE_SLOTS];
	bfha_pkg::slot_ent_t slot_mem [bfha_pkg::TABLE_SLOTS];
	logic [IW-1:0]       stk_mem  [bfha_pkg::TABLE_SLOTS];

	bfha_pkg::fl_ent_t   fl_rd_q;
	bfha_pkg::slot_ent_t slot_rd_q;
	logic [IW-1:0]       stk_rd_q;

	logic [3:0]          state_q;

	// item being served
	logic                func_q;
	logic [16:0]         size_q;
	logic [15:0]         off_q;

	// architectural counters
	logic [16:0]         bump_q;
	logic [CW-1:0]       slot_count_q;
	logic [CW-1:0]       stk_top_q;
	logic [CW-1:0]       freed_count_q;

	// working registers
	logic [CW-1:0]       idx_q;      // scan / shift position
	logic                fit_q;
	logic [15:0]         cstart_q;   // start of the chunk handed out
	logic [16:0]         clen_q;     // length of the fitting free chunk
	logic [15:0]         nstart_q;   // entry being inserted
	logic [16:0]         nlen_q;
	logic [IW-1:0]       slot_q;

	logic                done_q;
	bfha_pkg::bfha_rsp_t rsp_q;

	// memory port controls
	logic [IW-1:0]       fl_ra, slot_ra, stk_ra;
	logic                fl_we, slot_we, stk_we;
	logic [IW-1:0]       fl_wa, slot_wa, stk_wa;
	bfha_pkg::fl_ent_t   fl_wd;
	bfha_pkg::slot_ent_t slot_wd;
	logic [CW-1:0]       idx_inc, ins_km1, top_m1;
	logic [17:0]         bump_sum;

	assign idx_inc  = idx_q + CW'(1);
	assign ins_km1  = idx_q - CW'(1);
	assign top_m1   = stk_top_q - CW'(1);
	assign bump_sum = {1'b0, bump_q} + {1'b0, size_q};

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// memory read/write addresses and data
	always_comb begin
		fl_ra   = idx_q[IW-1:0];
		slot_ra = idx_q[IW-1:0];
		stk_ra  = top_m1[IW-1:0];
		fl_we   = 1'b0;
		fl_wa   = idx_q[IW-1:0];
		fl_wd   = fl_rd_q;
		slot_we = 1'b0;
		slot_wa = slot_q;
		slot_wd = '{valid: 1'b1, start: cstart_q, len: size_q};
		stk_we  = 1'b0;
		stk_wa  = stk_top_q[IW-1:0];
		unique case (state_q)
			S_RM_RD:   fl_ra = idx_inc[IW-1:0];
			S_RM_WR:   fl_we = 1'b1;
			S_INS_RD: begin
				fl_ra = ins_km1[IW-1:0];
				if (idx_q == '0) begin
					fl_we = 1'b1;
					fl_wd = '{start: nstart_q, len: nlen_q};
				end
			end
			S_INS_CK: begin
				fl_we = 1'b1;
				if (fl_rd_q.len <= nlen_q) fl_wd = '{start: nstart_q, len: nlen_q};
			end
			S_SLOT_WR: slot_we = 1'b1;
			S_FREE_DO: begin
				if (!(freed_count_q >= bfha_pkg::SLOTS_C || stk_top_q >= bfha_pkg::SLOTS_C)) begin
					slot_we = 1'b1;
					slot_wd = '{valid: 1'b0, start: nstart_q, len: nlen_q};
					stk_we  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fl_we) fl_mem[fl_wa] <= fl_wd;
		fl_rd_q <= fl_mem[fl_ra];
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd_q <= slot_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= slot_q;
		stk_rd_q <= stk_mem[stk_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			bump_q        <= '0;
			slot_count_q  <= '0;
			stk_top_q     <= '0;
			freed_count_q <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q   <= req.func;
						size_q   <= req.req_size;
						off_q    <= req.free_offset;
						idx_q    <= '0;
						fit_q    <= 1'b0;
						state_q  <= (req.func == bfha_pkg::FUNC_FREE) ? S_SSCAN_RD : S_FSCAN_RD;
					end
				end
				// first free chunk with len >= size
				S_FSCAN_RD: begin
					if (size_q == '0) begin
						done_q  <= 1'b1;
						rsp_q   <= '{offset: '0, status: bfha_pkg::ST_ZERO};
						state_q <= S_IDLE;
					end else if (idx_q >= freed_count_q) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_FSCAN_CK;
					end
				end
				S_FSCAN_CK: begin
					if (fl_rd_q.len >= size_q) begin
						fit_q    <= 1'b1;
						cstart_q <= fl_rd_q.start;
						clen_q   <= fl_rd_q.len;
						state_q  <= S_DECIDE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_FSCAN_RD;
					end
				end
				S_DECIDE: begin
					if (!fit_q && bump_sum > bfha_pkg::HEAP_C) begin
						done_q  <= 1'b1;
						rsp_q   <= '{offset: '0, status: bfha_pkg::ST_HEAP};
						state_q <= S_IDLE;
					end else if (stk_top_q == '0 && slot_count_q >= bfha_pkg::SLOTS_C) begin
						done_q  <= 1'b1;
						rsp_q   <= '{offset: '0, status: bfha_pkg::ST_TABLE};
						state_q <= S_IDLE;
					end else if (fit_q) begin
						state_q <= S_RM_RD;
					end else begin
						cstart_q <= bump_q[15:0];
						bump_q   <= bump_sum[16:0];
						state_q  <= S_STK;
					end
				end
				// close the gap left by the taken chunk
				S_RM_RD: begin
					if (idx_inc >= freed_count_q) begin
						if (clen_q > size_q) begin
							// remainder replaces the removed entry: count stays
							nstart_q <= cstart_q + size_q[15:0];
							nlen_q   <= clen_q - size_q;
							idx_q    <= freed_count_q - CW'(1);
							state_q  <= S_INS_RD;
						end else begin
							freed_count_q <= freed_count_q - CW'(1);
							state_q       <= S_STK;
						end
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin
					idx_q   <= idx_inc;
					state_q <= S_RM_RD;
				end
				// backward insertion, stable: stop at the first len <= new
				S_INS_RD: begin
					if (idx_q == '0) begin
						state_q <= (func_q == bfha_pkg::FUNC_ALLOC) ? S_STK : S_IDLE;
						if (func_q == bfha_pkg::FUNC_FREE) begin
							done_q <= 1'b1;
							rsp_q  <= '{offset: '0, status: bfha_pkg::ST_OK};
						end
					end else begin
						state_q <= S_INS_CK;
					end
				end
				S_INS_CK: begin
					if (fl_rd_q.len > nlen_q) begin
						idx_q   <= ins_km1;
						state_q <= S_INS_RD;
					end else begin
						state_q <= (func_q == bfha_pkg::FUNC_ALLOC) ? S_STK : S_IDLE;
						if (func_q == bfha_pkg::FUNC_FREE) begin
							done_q <= 1'b1;
							rsp_q  <= '{offset: '0, status: bfha_pkg::ST_OK};
						end
					end
				end
				// slot: reuse from the stack, else open a fresh one
				S_STK: begin
					if (stk_top_q != '0) begin
						stk_top_q <= top_m1;
						state_q   <= S_STK_CK;
					end else begin
						slot_q       <= slot_count_q[IW-1:0];
						slot_count_q <= slot_count_q + CW'(1);
						state_q      <= S_SLOT_WR;
					end
				end
				S_STK_CK: begin
					slot_q  <= stk_rd_q;
					state_q <= S_SLOT_WR;
				end
				S_SLOT_WR: begin
					done_q  <= 1'b1;
					rsp_q   <= '{offset: cstart_q, status: bfha_pkg::ST_OK};
					state_q <= S_IDLE;
				end
				// free: lowest valid slot with a matching start
				S_SSCAN_RD: begin
					if (idx_q >= slot_count_q) begin
						done_q  <= 1'b1;
						rsp_q   <= '{offset: '0, status: bfha_pkg::ST_NOTFOUND};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SSCAN_CK;
					end
				end
				S_SSCAN_CK: begin
					if (slot_rd_q.valid && slot_rd_q.start == off_q) begin
						slot_q   <= idx_q[IW-1:0];
						nstart_q <= slot_rd_q.start;
						nlen_q   <= slot_rd_q.len;
						state_q  <= S_FREE_DO;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_SSCAN_RD;
					end
				end
				S_FREE_DO: begin
					if (freed_count_q >= bfha_pkg::SLOTS_C || stk_top_q >= bfha_pkg::SLOTS_C) begin
						done_q  <= 1'b1;
						rsp_q   <= '{offset: '0, status: bfha_pkg::ST_TABLE};
						state_q <= S_IDLE;
					end else begin
						stk_top_q     <= stk_top_q + CW'(1);
						idx_q         <= freed_count_q;
						freed_count_q <= freed_count_q + CW'(1);
						state_q       <= S_INS_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/bfha_checker.sv @@
// Port-level checker for the best-fit heap allocator, with its bind.
// Depends on bfha_pkg and attaches to best_fit_heap_allocator_unit.
module bfha_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input bfha_pkg::bfha_rsp_t rsp
);

	// an accepted item always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	// the result goes out as the block frees up
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("item finished without a result");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != bfha_pkg::ST_OK |-> rsp.offset == '0)
		else $error("failed item carries an offset");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status <= bfha_pkg::ST_ZERO) else $error("status out of range");

endmodule

bind best_fit_heap_allocator_unit bfha_checker u_bfha_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .rsp(rsp)
);

@@ verif/best_fit_heap_allocator_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for best_fit_heap_allocator_unit: directed table, then random traffic.
// Depends on bfha_pkg and the allocator RTL; a heap model predicts items without a typed answer.
module best_fit_heap_allocator_unit_tb;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	bfha_pkg::bfha_req_t req;
	logic                done;
	bfha_pkg::bfha_rsp_t rsp;

	best_fit_heap_allocator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Heap model: slot table, LIFO of released slots, sorted free list
	// ---------------------------------------------------------------
	logic [15:0] slot_base [bfha_pkg::TABLE_SLOTS];
	logic [16:0] slot_bytes[bfha_pkg::TABLE_SLOTS];
	bit          slot_live [bfha_pkg::TABLE_SLOTS];
	int          slots_opened;
	logic [9:0]  spare_slot[bfha_pkg::TABLE_SLOTS];
	int          spare_depth;
	logic [15:0] hole_base [bfha_pkg::TABLE_SLOTS];
	logic [16:0] hole_bytes[bfha_pkg::TABLE_SLOTS];
	int          hole_count;
	int          bump;

	bfha_pkg::bfha_rsp_t pending_rsp[$];   // answers still owed by the block
	logic [15:0] live_offsets[$];  // chunks currently handed out, for picking frees
	int          mismatches;
	int          items_sent;
	int          n_alloc_ok, n_free_ok, n_fail;
	bit          steady;           // no idling on the request side

	// drop entry pos from the free list
	function automatic void hole_remove(int pos);
		for (int k = pos; k + 1 < hole_count; k++) begin
			hole_base[k]  = hole_base[k+1];
			hole_bytes[k] = hole_bytes[k+1];
		end
		hole_count--;
	endfunction

	// stable ascending insert: after every entry of equal or smaller length
	function automatic void hole_insert(logic [15:0] base, logic [16:0] len);
		int pos;
		pos = 0;
		if (hole_count >= bfha_pkg::TABLE_SLOTS)
			return;
		while (pos < hole_count && hole_bytes[pos] <= len)
			pos++;
		for (int k = hole_count; k > pos; k--) begin
			hole_base[k]  = hole_base[k-1];
			hole_bytes[k] = hole_bytes[k-1];
		end
		hole_base[pos]  = base;
		hole_bytes[pos] = len;
		hole_count++;
	endfunction

	function automatic bfha_pkg::bfha_rsp_t heap_answer(bfha_pkg::bfha_req_t r);
		bfha_pkg::bfha_rsp_t a;
		int          pos, s, slot;
		bit          fit;
		logic [15:0] base;
		logic [16:0] len;
		a.offset = '0;
		a.status = bfha_pkg::ST_OK;
		if (r.func == bfha_pkg::FUNC_ALLOC) begin
			if (r.req_size == 0) begin
				a.status = bfha_pkg::ST_ZERO;
				return a;
			end
			fit = 0;
			for (pos = 0; pos < hole_count; pos++)
				if (hole_bytes[pos] >= r.req_size) begin
					fit = 1;
					break;
				end
			if (!fit && bump + int'(r.req_size) > bfha_pkg::HEAP_BYTES) begin
				a.status = bfha_pkg::ST_HEAP;
				return a;
			end
			if (spare_depth == 0 && slots_opened >= bfha_pkg::TABLE_SLOTS) begin
				a.status = bfha_pkg::ST_TABLE;
				return a;
			end
			if (fit) begin
				base = hole_base[pos];
				len  = hole_bytes[pos];
				hole_remove(pos);
				if (len > r.req_size)
					hole_insert(base + r.req_size[15:0], len - r.req_size);
			end else begin
				base = bump[15:0];
				bump = (bump + int'(r.req_size)) & 32'h1FFFF;
			end
			if (spare_depth > 0) begin
				spare_depth--;
				slot = spare_slot[spare_depth];
			end else begin
				slot = slots_opened;
				slots_opened++;
			end
			slot_base[slot]  = base;
			slot_bytes[slot] = r.req_size;
			slot_live[slot]  = 1;
			a.offset = base;
		end else begin
			for (s = 0; s < bfha_pkg::TABLE_SLOTS; s++)
				if (slot_live[s] && slot_base[s] == r.free_offset)
					break;
			if (s >= bfha_pkg::TABLE_SLOTS) begin
				a.status = bfha_pkg::ST_NOTFOUND;
				return a;
			end
			if (hole_count >= bfha_pkg::TABLE_SLOTS || spare_depth >= bfha_pkg::TABLE_SLOTS) begin
				a.status = bfha_pkg::ST_TABLE;
				return a;
			end
			slot_live[s] = 0;
			spare_slot[spare_depth] = s[9:0];
			spare_depth++;
			hole_insert(slot_base[s], slot_bytes[s]);
		end
		return a;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("MISMATCH t=%0t %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------
	// Response checker; the receiver cannot stall, so every strobe counts
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		bfha_pkg::bfha_rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected response", rsp.offset, 16'd0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.offset !== want.offset)
					report("offset", rsp.offset, want.offset);
				if (rsp.status !== want.status)
					report("status", 16'(rsp.status), 16'(want.status));
			end
		end
	end

	// Drive one item and hold it until the block takes it. With typed_in set, the
	// answer written in the table is expected instead of the model's; the model
	// still steps so that its state follows the block.
	task automatic issue(bfha_pkg::bfha_req_t r, bit typed_in, bfha_pkg::bfha_rsp_t typed);
		bfha_pkg::bfha_rsp_t a;
		while (!steady && $urandom_range(99) < 17) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		// item accepted at this edge
		a = heap_answer(r);
		if (a.status == bfha_pkg::ST_OK) begin
			if (r.func == bfha_pkg::FUNC_ALLOC) begin
				n_alloc_ok++;
				live_offsets.push_back(a.offset);
			end else begin
				n_free_ok++;
				foreach (live_offsets[i])
					if (live_offsets[i] == r.free_offset) begin
						live_offsets.delete(i);
						break;
					end
			end
		end else begin
			n_fail++;
		end
		pending_rsp.push_back(typed_in ? typed : a);
		items_sent++;
	endtask

	function automatic bfha_pkg::bfha_req_t mk(logic f, int sz, int off);
		bfha_pkg::bfha_req_t r;
		r.func        = f;
		r.req_size    = 17'(sz);
		r.free_offset = 16'(off);
		return r;
	endfunction

	typedef struct {
		logic        f;
		int          sz;
		int          off;
		bit          typed_in;
		logic [15:0] exp_off;
		logic [2:0]  exp_st;
	} row_t;

	// Directed rows: extremes, every status but table full, split, reuse of holes and slots.
	localparam int N_ROWS = 22;
	row_t script[N_ROWS] = '{
		'{bfha_pkg::FUNC_ALLOC, 0,       0,      1, 16'd0,  bfha_pkg::ST_ZERO}, // zero size
		'{bfha_pkg::FUNC_ALLOC, 'h1FFFF, 0,      1, 16'd0,  bfha_pkg::ST_HEAP}, // all bits set
		'{bfha_pkg::FUNC_ALLOC, 65537,   0,      1, 16'd0,  bfha_pkg::ST_HEAP}, // one past heap
		'{bfha_pkg::FUNC_FREE,  0,       0,      1, 16'd0,  bfha_pkg::ST_NOTFOUND}, // empty
		'{bfha_pkg::FUNC_FREE,  0,       'hFFFF, 1, 16'd0,  bfha_pkg::ST_NOTFOUND},
		'{bfha_pkg::FUNC_ALLOC, 16,      0,      1, 16'd0,  bfha_pkg::ST_OK}, // first bump
		'{bfha_pkg::FUNC_ALLOC, 32,      0,      1, 16'd16, bfha_pkg::ST_OK},
		'{bfha_pkg::FUNC_ALLOC, 16,      0,      1, 16'd48, bfha_pkg::ST_OK},
		'{bfha_pkg::FUNC_ALLOC, 100,     0,      1, 16'd64, bfha_pkg::ST_OK},
		'{bfha_pkg::FUNC_FREE,  'h1FFFF, 16,     1, 16'd0,  bfha_pkg::ST_OK}, // size ignored
		'{bfha_pkg::FUNC_FREE,  0,       0,      1, 16'd0,  bfha_pkg::ST_OK},
		'{bfha_pkg::FUNC_FREE,  0,       0,      1, 16'd0,  bfha_pkg::ST_NOTFOUND}, // twice
		'{bfha_pkg::FUNC_ALLOC, 8,       'hFFFF, 0, 16'd0,  bfha_pkg::ST_OK}, // split small
		'{bfha_pkg::FUNC_ALLOC, 20,      0,      0, 16'd0,  bfha_pkg::ST_OK}, // split larger
		'{bfha_pkg::FUNC_ALLOC, 16,      0,      0, 16'd0,  bfha_pkg::ST_OK}, // no fit: bump
		'{bfha_pkg::FUNC_ALLOC, 8,       0,      0, 16'd0,  bfha_pkg::ST_OK}, // exact fit
		'{bfha_pkg::FUNC_FREE,  0,       48,     0, 16'd0,  bfha_pkg::ST_OK},
		'{bfha_pkg::FUNC_FREE,  0,       64,     0, 16'd0,  bfha_pkg::ST_OK},
		'{bfha_pkg::FUNC_ALLOC, 16,      0,      0, 16'd0,  bfha_pkg::ST_OK}, // equal lengths
		'{bfha_pkg::FUNC_ALLOC, 40000,   0,      0, 16'd0,  bfha_pkg::ST_OK},
		'{bfha_pkg::FUNC_ALLOC, 30000,   0,      1, 16'd0,  bfha_pkg::ST_HEAP}, // bump runs out
		'{bfha_pkg::FUNC_ALLOC, 65536,   0,      0, 16'd0,  bfha_pkg::ST_OK} // whole-heap size
	};

	function automatic int pick_size();
		int p;
		p = $urandom_range(99);
		if (p < 70) return $urandom_range(64, 1);
		if (p < 90) return $urandom_range(1024, 65);
		if (p < 97) return $urandom_range(8192, 1025);
		if (p < 98) return 0;
		return $urandom_range('h1FFFF, 'h8000);
	endfunction

	initial begin
		bfha_pkg::bfha_req_t r;
		bfha_pkg::bfha_rsp_t t;
		int        p;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		steady = 0;
		mismatches = 0;
		items_sent = 0;
		n_alloc_ok = 0;
		n_free_ok  = 0;
		n_fail     = 0;
		bump = 0;
		slots_opened = 0;
		spare_depth  = 0;
		hole_count   = 0;
		foreach (slot_live[i])
			slot_live[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			t.offset = script[i].exp_off;
			t.status = script[i].exp_st;
			issue(mk(script[i].f, script[i].sz, script[i].off), script[i].typed_in, t);
		end

		// random mix; frees mostly target live chunks, some stale or arbitrary
		for (int n = 0; n < 270; n++) begin
			steady = (n >= 100 && n < 160);
			p = $urandom_range(99);
			if (p < 55 || live_offsets.size() == 0)
				r = mk(bfha_pkg::FUNC_ALLOC, pick_size(), $urandom_range(16'hFFFF));
			else if (p < 88)
				r = mk(bfha_pkg::FUNC_FREE, $urandom_range('h1FFFF),
					live_offsets[$urandom_range(live_offsets.size() - 1)]);
			else
				r = mk(bfha_pkg::FUNC_FREE, $urandom_range('h1FFFF), $urandom_range(16'hFFFF));
			issue(r, 0, t);
		end
		steady = 0;
		start <= 1'b0;

		fork
			wait (pending_rsp.size() == 0);
			repeat (2000000) @(posedge clk);
		join_any
		disable fork;
		repeat (20) @(posedge clk);

		$display("Ran %0d items: %0d allocations and %0d frees succeeded, %0d refused.",
			items_sent, n_alloc_ok, n_free_ok, n_fail);
		$display("Heap bump at %0d, %0d slots opened, %0d holes listed.",
			bump, slots_opened, hole_count);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("TIMEOUT with %0d responses outstanding", pending_rsp.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
